// ===== src/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the minimum coin change block
// Command codes, sequencer states, table entry encoding and the control
// and status groups passed between the sequencer and the relaxation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

   // Payload widths fixed by the channel definition
   localparam int VALUE_W = 10;
   localparam int COUNT_W = 10;
   localparam int ENTRY_W = 11;

   // All-ones table entry marks an amount that cannot be formed
   localparam logic [ENTRY_W-1:0] UNREACH = {ENTRY_W{1'b1}};

   // Largest amount a request beat can carry
   localparam int VALUE_MAX = (1 << VALUE_W) - 1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   // Sequencer to relaxation unit
   typedef struct packed {
      logic clear;
      logic coin_valid;
   } relax_ctl_type;

   // Relaxation unit to sequencer
   typedef struct packed {
      logic busy;
   } relax_sts_type;

endpackage

`default_nettype wire

// ===== src/mcc_if.sv =====
// ----------------------------------------------------------------------------
// mcc_req_if / mcc_rsp_if: request and response channels
// Valid/ready channels; a beat moves on a rising edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 cmd;
   logic [mcc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mcc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mcc_pkg::COUNT_W-1:0] fewest;
   logic                        reachable;

   modport source (output valid, output fewest, output reachable, input ready);
   modport sink   (input valid, input fewest, input reachable, output ready);
endinterface

`default_nettype wire

// ===== src/min_coin_change_dp.sv =====
// ----------------------------------------------------------------------------
// min_coin_change_dp: fewest coins for a target amount, unbounded coin use
//
// Request beats carry cmd and value. A load beat stores a nonzero coin while
// fewer than MAX_COINS are held; a clear beat empties the store; neither gives
// a response. A query beat fills a table of fewest-coin counts from amount 0
// up to the target and returns one response beat with fewest and reachable
// (fewest is zero when the target cannot be made). For each amount the
// sequencer runs every stored coin through one shared compare-and-update
// unit, one coin per cycle, then drains its two-stage fetch and writes the
// table entry. Targets of zero or above MAX_AMOUNT skip the table and go
// straight to the result. Request ready is high only in the idle state, so
// one beat is worked at a time. A finished response waits in the output
// register while the receiver stalls, and a load or clear is taken
// meanwhile; a further query completes but holds its answer until the
// register frees. Reset empties the coin store and returns to idle; the
// table needs no clearing since a query writes every entry before it reads
// it.
// ----------------------------------------------------------------------------
`default_nettype none

module min_coin_change_dp #(
   parameter int MAX_COINS  = 16,
   parameter int MAX_AMOUNT = 1023
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mcc_req_if.sink    req_chan,
   mcc_rsp_if.source  rsp_chan
);

   localparam int VW         = mcc_pkg::VALUE_W;
   localparam int EW         = mcc_pkg::ENTRY_W;
   localparam int TOP_AMOUNT = (MAX_AMOUNT < mcc_pkg::VALUE_MAX) ? MAX_AMOUNT
                                                                 : mcc_pkg::VALUE_MAX;
   localparam int TBL_DEPTH  = TOP_AMOUNT + 1;
   localparam int TAW        = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam int NW         = $clog2(MAX_COINS + 1);
   localparam int CAW        = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

   localparam logic [NW-1:0] COIN_CAP   = NW'(MAX_COINS);
   localparam logic [VW-1:0] AMOUNT_CAP = VW'(TOP_AMOUNT);

   mcc_pkg::state_type state_ff, state_in;
   logic [NW-1:0]      total_ff, total_in;
   logic [NW-1:0]      k_ff, k_in;
   logic [VW-1:0]      amt_ff, amt_in;
   logic [VW-1:0]      target_ff, target_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [VW-1:0]      res_count_ff, res_count_in;
   logic               res_reach_ff, res_reach_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]      rsp_count_ff, rsp_count_in;
   logic               rsp_reach_ff, rsp_reach_in;

   logic               req_accept;
   logic               coin_we;
   logic [CAW-1:0]     coin_wr_addr;
   logic [CAW-1:0]     coin_rd_addr;
   logic [VW-1:0]      coin_rdata;
   logic               tbl_we;
   logic [TAW-1:0]     tbl_wr_addr;
   logic [EW-1:0]      tbl_wr_data;
   logic [TAW-1:0]     tbl_rd_addr;
   logic [EW-1:0]      tbl_rdata;

   mcc_pkg::relax_ctl_type relax_ctl;
   mcc_pkg::relax_sts_type relax_sts;
   logic [VW-1:0]          rd_offset;
   logic [EW-1:0]          best;

   assign req_chan.ready = (state_ff == mcc_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Coin store
   mcc_ram #(.WIDTH(VW), .DEPTH(MAX_COINS)) u_coin_ram (
      .clock   (clock),
      .wr_en   (coin_we),
      .wr_addr (coin_wr_addr),
      .wr_data (req_chan.value),
      .rd_addr (coin_rd_addr),
      .rd_data (coin_rdata)
   );

   // Fewest-coin table
   mcc_ram #(.WIDTH(EW), .DEPTH(TBL_DEPTH)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rdata)
   );

   assign tbl_rd_addr = rd_offset[TAW-1:0];

   mcc_relax u_relax (
      .clock     (clock),
      .reset     (reset),
      .ctl       (relax_ctl),
      .coin      (coin_rdata),
      .amount    (amt_ff),
      .prev      (tbl_rdata),
      .rd_offset (rd_offset),
      .sts       (relax_sts),
      .best      (best)
   );

   // Sequencer: next state, counters and memory controls
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      amt_in       = amt_ff;
      target_in    = target_ff;
      s1_valid_in  = 1'b0;
      res_count_in = res_count_ff;
      res_reach_in = res_reach_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in = rsp_count_ff;
      rsp_reach_in = rsp_reach_ff;

      coin_we      = 1'b0;
      coin_wr_addr = total_ff[CAW-1:0];
      coin_rd_addr = k_ff[CAW-1:0];
      tbl_we       = 1'b0;
      tbl_wr_addr  = amt_ff[TAW-1:0];
      tbl_wr_data  = best;

      relax_ctl.clear      = 1'b0;
      relax_ctl.coin_valid = s1_valid_ff;

      case (state_ff)
         mcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.cmd == mcc_pkg::CMD_LOAD) begin
                  // Drop zero coins and loads into a full store
                  if ((req_chan.value != '0) && (total_ff < COIN_CAP)) begin
                     coin_we  = 1'b1;
                     total_in = total_ff + NW'(1);
                  end
               end else if (req_chan.cmd == mcc_pkg::CMD_CLEAR) begin
                  total_in = '0;
               end else if (req_chan.cmd == mcc_pkg::CMD_QUERY) begin
                  target_in = req_chan.value;
                  if (req_chan.value > AMOUNT_CAP) begin
                     res_count_in = '0;
                     res_reach_in = 1'b0;
                     state_in     = mcc_pkg::ST_RESULT;
                  end else if (req_chan.value == '0) begin
                     res_count_in = '0;
                     res_reach_in = 1'b1;
                     state_in     = mcc_pkg::ST_RESULT;
                  end else begin
                     // Seed amount zero, start at amount one
                     tbl_we          = 1'b1;
                     tbl_wr_addr     = '0;
                     tbl_wr_data     = '0;
                     amt_in          = VW'(1);
                     k_in            = '0;
                     relax_ctl.clear = 1'b1;
                     state_in        = mcc_pkg::ST_SCAN;
                  end
               end
            end
         end

         mcc_pkg::ST_SCAN: begin
            // Issue one coin fetch a cycle
            if (k_ff < total_ff) begin
               s1_valid_in = 1'b1;
               k_in        = k_ff + NW'(1);
            end else begin
               state_in = mcc_pkg::ST_DRAIN;
            end
         end

         mcc_pkg::ST_DRAIN: begin
            // Wait for the last fold to land
            if (!s1_valid_ff && !relax_sts.busy) begin
               state_in = mcc_pkg::ST_COMMIT;
            end
         end

         mcc_pkg::ST_COMMIT: begin
            tbl_we = 1'b1;
            if (amt_ff == target_ff) begin
               if (best == mcc_pkg::UNREACH) begin
                  res_count_in = '0;
                  res_reach_in = 1'b0;
               end else begin
                  res_count_in = best[VW-1:0];
                  res_reach_in = 1'b1;
               end
               state_in = mcc_pkg::ST_RESULT;
            end else begin
               amt_in          = amt_ff + VW'(1);
               k_in            = '0;
               relax_ctl.clear = 1'b1;
               state_in        = mcc_pkg::ST_SCAN;
            end
         end

         mcc_pkg::ST_RESULT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_count_ff;
               rsp_reach_in = res_reach_ff;
               state_in     = mcc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcc_pkg::ST_IDLE;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff         <= k_in;
      amt_ff       <= amt_in;
      target_ff    <= target_in;
      res_count_ff <= res_count_in;
      res_reach_ff <= res_reach_in;
      rsp_count_ff <= rsp_count_in;
      rsp_reach_ff <= rsp_reach_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.fewest    = rsp_count_ff;
   assign rsp_chan.reachable = rsp_reach_ff;

   // A response beat only appears after the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mcc_pkg::ST_RESULT))
      else $error("response raised outside the result state");

   // The fetch pipeline is empty whenever a new beat can be taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcc_pkg::ST_IDLE) |-> (!s1_valid_ff && !relax_sts.busy))
      else $error("fetch pipeline busy while idle");

   // Commit only writes amounts between one and the target
   a_commit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcc_pkg::ST_COMMIT) |-> ((amt_ff != '0) && (amt_ff <= target_ff)))
      else $error("commit outside the query range");

   // Coin count never passes the store capacity
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= COIN_CAP)
      else $error("coin count beyond capacity");

   // A coin fetch is only issued for a stored coin
   a_fetch_in_store: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ($past(k_ff) < total_ff))
      else $error("coin fetch beyond stored coins");

endmodule

`default_nettype wire

// ===== src/mcc_ram.sv =====
// ----------------------------------------------------------------------------
// mcc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/mcc_relax.sv =====
// ----------------------------------------------------------------------------
// mcc_relax: shared compare-and-update unit
// Takes one coin per cycle, forms the table offset amount - coin, and on the
// following cycle folds the fetched entry plus one into the running best.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_relax (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mcc_pkg::relax_ctl_type        ctl,
   input  wire logic [mcc_pkg::VALUE_W-1:0]   coin,
   input  wire logic [mcc_pkg::VALUE_W-1:0]   amount,
   input  wire logic [mcc_pkg::ENTRY_W-1:0]   prev,
   output logic      [mcc_pkg::VALUE_W-1:0]   rd_offset,
   output mcc_pkg::relax_sts_type             sts,
   output logic      [mcc_pkg::ENTRY_W-1:0]   best
);

   logic                          fold_ff;
   logic                          fold_in;
   logic [mcc_pkg::ENTRY_W-1:0]   best_ff;
   logic [mcc_pkg::ENTRY_W-1:0]   best_in;
   logic [mcc_pkg::ENTRY_W-1:0]   cand;

   // Coin stage: usable coins fetch the entry at amount - coin
   assign rd_offset = amount - coin;
   assign fold_in   = ctl.coin_valid && (coin <= amount);

   // Fold stage: keep the smaller of best and entry + 1
   assign cand = prev + mcc_pkg::ENTRY_W'(1);

   always_comb begin
      best_in = best_ff;
      if (ctl.clear) begin
         best_in = mcc_pkg::UNREACH;
      end else if (fold_ff && (prev != mcc_pkg::UNREACH) && (cand < best_ff)) begin
         best_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= 1'b0;
      end else begin
         fold_ff <= fold_in;
      end
      best_ff <= best_in;
   end

   assign sts.busy = fold_ff;
   assign best     = best_ff;

endmodule

`default_nettype wire
